// ===== rtl/ttwc_pkg.sv =====
// Shared types and constants for the trigger time-window clustering block.
// Used by ttwc_ctrl, ttwc_datapath and trigger_time_window_cluster.
package ttwc_pkg;

  localparam int TIME_W   = 61;
  localparam int STAT_W   = 32;
  localparam int TAG_W    = 32;
  localparam int WINDOW_W = 40;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;
  localparam int SQ_W     = 2 * STAT_W;
  localparam int ACC_W    = SQ_W + STAT_W;
  localparam int STEP_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd10000000;

  localparam logic [MODE_W-1:0] MODE_SNR_CHISQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RATIO     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SNR       = 2'd2;

  // Schedule of the shared 32x32 multiplier for the ratio comparison.
  localparam logic [STEP_W-1:0] STEP_SQ_NEW  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SQ_HELD = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NEW_LO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_NEW_HI  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_HELD_LO = 3'd4;
  localparam logic [STEP_W-1:0] STEP_HELD_HI = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ACC     = 3'd6;
  localparam logic [STEP_W-1:0] STEP_CMP     = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_MUL,
    S_EMIT_OLD,
    S_LOAD,
    S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic              cap_in;
    logic              cmp_en;
    logic              mul_en;
    logic [STEP_W-1:0] mul_step;
    logic              emit_old;
    logic              load_held;
    logic              flush;
  } dp_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic joins;
    logic mode_ratio;
    logic in_end;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/ttwc_ctrl.sv =====
// Controller state machine of the clustering block.
// Depends on ttwc_pkg; drives the datapath commands and the input stall.
module ttwc_ctrl import ttwc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.joins && sts.mode_ratio) state_nxt = S_MUL;
        else if (sts.held_valid && !sts.joins) state_nxt = S_EMIT_OLD;
        else state_nxt = S_LOAD;
      end
      S_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_CMP) state_nxt = S_LOAD;
      end
      S_EMIT_OLD: begin
        if (sts.out_free) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = sts.in_end ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_step = step_r;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.cap_in = in_valid;
      end
      S_CMP:      cmd.cmp_en    = 1'b1;
      S_MUL:      cmd.mul_en    = 1'b1;
      S_EMIT_OLD: cmd.emit_old  = sts.out_free;
      S_LOAD:     cmd.load_held = 1'b1;
      S_FLUSH:    cmd.flush     = sts.out_free;
      default:    cmd           = '0;
    endcase
  end

endmodule

// ===== rtl/ttwc_datapath.sv =====
// Datapath of the clustering block: configuration, captured trigger, held
// representative, shared multiplier for the ratio test and output register.
// Depends on ttwc_pkg.
module ttwc_datapath import ttwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [TIME_W-1:0]     in_end_time_ns,
  input  logic [STAT_W-1:0]     in_snr_value,
  input  logic [STAT_W-1:0]     in_chisq_value,
  input  logic [TAG_W-1:0]      in_trigger_tag,
  input  logic                  in_stream_end,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_end_time_ns,
  output logic [STAT_W-1:0]     out_snr,
  output logic [STAT_W-1:0]     out_chisq,
  output logic [TAG_W-1:0]      out_tag,
  output logic                  out_run_last
);

  logic [WINDOW_W-1:0] window_r;
  logic [MODE_W-1:0]   mode_r;

  logic [TIME_W-1:0] in_time_r;
  logic [STAT_W-1:0] in_snr_r;
  logic [STAT_W-1:0] in_chisq_r;
  logic [TAG_W-1:0]  in_tag_r;
  logic              in_end_r;

  logic              held_valid_r;
  logic [TIME_W-1:0] held_time_r;
  logic [STAT_W-1:0] held_snr_r;
  logic [STAT_W-1:0] held_chisq_r;
  logic [TAG_W-1:0]  held_tag_r;

  logic              join_r;
  logic              better_r;
  logic [SQ_W-1:0]   prod_r;
  logic [SQ_W-1:0]   sqn_r;
  logic [SQ_W-1:0]   sqh_r;
  logic [ACC_W-1:0]  accn_r;
  logic [ACC_W-1:0]  acch_r;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_time_r;
  logic [STAT_W-1:0] out_snr_r;
  logic [STAT_W-1:0] out_chisq_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_last_r;

  logic [TIME_W-1:0] diff_w;
  logic              joins_w;
  logic              simple_better_w;
  logic [STAT_W-1:0] mul_a;
  logic [STAT_W-1:0] mul_b;
  logic              out_free_w;
  logic              take_w;

  // A time earlier than the held one counts as inside the window.
  assign diff_w  = in_time_r - held_time_r;
  assign joins_w = held_valid_r &&
                   ((in_time_r < held_time_r) ||
                    (diff_w < {{(TIME_W-WINDOW_W){1'b0}}, window_r}));

  always_comb begin
    case (mode_r)
      MODE_SNR_CHISQ: simple_better_w = (in_snr_r > held_snr_r) && (in_chisq_r < held_chisq_r);
      MODE_SNR:       simple_better_w = in_snr_r > held_snr_r;
      default:        simple_better_w = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.mul_step)
      STEP_SQ_NEW: begin
        mul_a = in_snr_r;
        mul_b = in_snr_r;
      end
      STEP_SQ_HELD: begin
        mul_a = held_snr_r;
        mul_b = held_snr_r;
      end
      STEP_NEW_LO: begin
        mul_a = sqn_r[STAT_W-1:0];
        mul_b = held_chisq_r;
      end
      STEP_NEW_HI: begin
        mul_a = sqn_r[SQ_W-1:STAT_W];
        mul_b = held_chisq_r;
      end
      STEP_HELD_LO: begin
        mul_a = sqh_r[STAT_W-1:0];
        mul_b = in_chisq_r;
      end
      STEP_HELD_HI: begin
        mul_a = sqh_r[SQ_W-1:STAT_W];
        mul_b = in_chisq_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_free_w = !out_valid_r || !out_stall;
  assign take_w     = !join_r || better_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      mode_r   <= MODE_SNR_CHISQ;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW: window_r <= cfg_wr_data[WINDOW_W-1:0];
        REG_MODE:   mode_r   <= cfg_wr_data[MODE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_time_r  <= in_end_time_ns;
      in_snr_r   <= in_snr_value;
      in_chisq_r <= in_chisq_value;
      in_tag_r   <= in_trigger_tag;
      in_end_r   <= in_stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      join_r   <= joins_w;
      better_r <= simple_better_w;
    end
    // The product of each step lands in prod_r and is consumed a step later.
    if (cmd.mul_en) begin
      prod_r <= SQ_W'(mul_a * mul_b);
      case (cmd.mul_step)
        STEP_SQ_HELD: sqn_r <= prod_r;
        STEP_NEW_LO:  sqh_r <= prod_r;
        STEP_NEW_HI:  accn_r <= {{STAT_W{1'b0}}, prod_r};
        STEP_HELD_LO: accn_r[ACC_W-1:STAT_W] <= accn_r[ACC_W-1:STAT_W] + prod_r;
        STEP_HELD_HI: acch_r <= {{STAT_W{1'b0}}, prod_r};
        STEP_ACC:     acch_r[ACC_W-1:STAT_W] <= acch_r[ACC_W-1:STAT_W] + prod_r;
        STEP_CMP:     better_r <= accn_r > acch_r;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (cmd.flush) begin
      held_valid_r <= 1'b0;
    end else if (cmd.load_held) begin
      held_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_held && take_w) begin
      held_time_r  <= in_time_r;
      held_snr_r   <= in_snr_r;
      held_chisq_r <= in_chisq_r;
      held_tag_r   <= in_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_old || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_old || cmd.flush) begin
      out_time_r  <= held_time_r;
      out_snr_r   <= held_snr_r;
      out_chisq_r <= held_chisq_r;
      out_tag_r   <= held_tag_r;
      out_last_r  <= cmd.flush || !in_end_r;
    end
  end

  always_comb begin
    sts.held_valid = held_valid_r;
    sts.joins      = joins_w;
    sts.mode_ratio = (mode_r == MODE_RATIO);
    sts.in_end     = in_end_r;
    sts.out_free   = out_free_w;
  end

  assign out_valid       = out_valid_r;
  assign out_end_time_ns = out_time_r;
  assign out_snr         = out_snr_r;
  assign out_chisq       = out_chisq_r;
  assign out_tag         = out_tag_r;
  assign out_run_last    = out_last_r;

endmodule

// ===== rtl/trigger_time_window_cluster.sv =====
// Trigger clustering over a time window: top level joining ttwc_ctrl and
// ttwc_datapath. Depends on ttwc_pkg.
// An item passes accept, window compare and held update; a joining trigger ranked in the
// ratio mode adds eight multiplier steps, and an emit or flush adds a state that waits for a free output.
// An old representative is emitted after the window compare, a flushed one after the held update.
// Synchronous active-low reset empties the cluster, output and control and restores config.
module trigger_time_window_cluster import ttwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_end_time_ns,
  input  logic [STAT_W-1:0]     in_snr_value,
  input  logic [STAT_W-1:0]     in_chisq_value,
  input  logic [TAG_W-1:0]      in_trigger_tag,
  input  logic                  in_stream_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_end_time_ns,
  output logic [STAT_W-1:0]     out_snr,
  output logic [STAT_W-1:0]     out_chisq,
  output logic [TAG_W-1:0]      out_tag,
  output logic                  out_run_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ttwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttwc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_end_time_ns  (in_end_time_ns),
    .in_snr_value    (in_snr_value),
    .in_chisq_value  (in_chisq_value),
    .in_trigger_tag  (in_trigger_tag),
    .in_stream_end   (in_stream_end),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_end_time_ns (out_end_time_ns),
    .out_snr         (out_snr),
    .out_chisq       (out_chisq),
    .out_tag         (out_tag),
    .out_run_last    (out_run_last)
  );

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_old || cmd.flush) |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  // After a flush nothing is held.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !sts.held_valid)
    else $error("held trigger survived a flush");

  // While a transaction can be taken, no item is still being worked on.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(cmd.load_held || cmd.emit_old || cmd.flush || cmd.mul_en))
    else $error("input open while an item is in progress");

  // The multiplier runs only for the ratio mode on a joining trigger; the check asks for ratio mode and a held trigger.
  a_mul_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> (sts.mode_ratio && sts.held_valid))
    else $error("multiplier started outside the ratio comparison");

endmodule

// ===== verif/tb_trigger_time_window_cluster.sv =====
// Testbench for trigger_time_window_cluster: directed and random trigger streams under every
// cluster mode and window extreme, checked against a behavioural model of the clustering.
// Depends on ttwc_pkg and the RTL of trigger_time_window_cluster.
`timescale 1ns / 1ps

module tb_trigger_time_window_cluster;
  import ttwc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [TIME_W-1:0] trig_time;
    logic [STAT_W-1:0] snr;
    logic [STAT_W-1:0] chisq;
    logic [TAG_W-1:0]  tag;
    logic              closing;
  } trigger_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_end_time_ns = '0;
  logic [STAT_W-1:0]     in_snr_value = '0;
  logic [STAT_W-1:0]     in_chisq_value = '0;
  logic [TAG_W-1:0]      in_trigger_tag = '0;
  logic                  in_stream_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TIME_W-1:0]     out_end_time_ns;
  logic [STAT_W-1:0]     out_snr;
  logic [STAT_W-1:0]     out_chisq;
  logic [TAG_W-1:0]      out_tag;
  logic                  out_run_last;

  // Model state: configuration and the held cluster representative.
  logic [WINDOW_W-1:0] window_setting = WINDOW_RESET;
  logic [MODE_W-1:0]   mode_setting = MODE_SNR_CHISQ;
  logic                cluster_held = 1'b0;
  trigger_t            held = '0;
  logic [TIME_W-1:0]   last_time = '0;

  trigger_t pending_clusters[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  trigger_time_window_cluster dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_end_time_ns(in_end_time_ns),
    .in_snr_value(in_snr_value),
    .in_chisq_value(in_chisq_value),
    .in_trigger_tag(in_trigger_tag),
    .in_stream_end(in_stream_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_end_time_ns(out_end_time_ns),
    .out_snr(out_snr),
    .out_chisq(out_chisq),
    .out_tag(out_tag),
    .out_run_last(out_run_last)
  );

  always #4 clk = ~clk;

  function automatic logic outranks_held(trigger_t trg);
    logic [95:0] new_score;
    logic [95:0] held_score;
    new_score = {64'b0, trg.snr} * {64'b0, trg.snr} * {64'b0, held.chisq};
    held_score = {64'b0, held.snr} * {64'b0, held.snr} * {64'b0, trg.chisq};
    case (mode_setting)
      MODE_SNR_CHISQ: return (trg.snr > held.snr) && (trg.chisq < held.chisq);
      MODE_RATIO:     return new_score > held_score;
      MODE_SNR:       return trg.snr > held.snr;
      default:        return 1'b0;
    endcase
  endfunction

  task automatic update_cluster(input trigger_t trg);
    logic joins;
    trigger_t emitted;
    joins = cluster_held &&
            ((trg.trig_time < held.trig_time) ||
             ((trg.trig_time - held.trig_time) < {{(TIME_W-WINDOW_W){1'b0}}, window_setting}));
    if (joins) begin
      if (outranks_held(trg)) begin
        held = trg;
      end
    end else begin
      if (cluster_held) begin
        emitted = held;
        emitted.closing = !trg.closing;
        pending_clusters.push_back(emitted);
      end
      cluster_held = 1'b1;
      held = trg;
    end
    if (trg.closing) begin
      emitted = held;
      emitted.closing = 1'b1;
      pending_clusters.push_back(emitted);
      cluster_held = 1'b0;
    end
  endtask

  // One transaction on the input channel; valid stays high unless the next call idles.
  task automatic send_trigger(input trigger_t trg);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_end_time_ns <= trg.trig_time;
    in_snr_value <= trg.snr;
    in_chisq_value <= trg.chisq;
    in_trigger_tag <= trg.tag;
    in_stream_end <= trg.closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_cluster(trg);
    last_time = trg.trig_time;
  endtask

  function automatic trigger_t make_trigger(input logic [TIME_W-1:0] t,
                                            input logic [STAT_W-1:0] snr,
                                            input logic [STAT_W-1:0] chisq,
                                            input logic [TAG_W-1:0] tag,
                                            input logic closing);
    trigger_t trg;
    trg.trig_time = t;
    trg.snr = snr;
    trg.chisq = chisq;
    trg.tag = tag;
    trg.closing = closing;
    return trg;
  endfunction

  task automatic wait_for_clusters();
    in_valid <= 1'b0;
    while (pending_clusters.size() != 0) @(posedge clk);
    // A trigger that joins the cluster leaves no result behind, so let it settle.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [WINDOW_W-1:0] window,
                                input logic [MODE_W-1:0] mode);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    wait_for_clusters();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_wr_data <= window;
    @(posedge clk);
    window_setting = window;
    // Bits above the mode field are expected to be ignored.
    cfg_index <= REG_MODE;
    cfg_wr_data <= {junk[CFG_DATA_W-1:MODE_W], mode};
    @(posedge clk);
    mode_setting = mode;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [STAT_W-1:0] pick_stat();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STAT_W'($urandom_range(0, 255));
      default: return STAT_W'($urandom);
    endcase
  endfunction

  // Mostly steps around the window edge, with some backward and arbitrary jumps.
  function automatic logic [TIME_W-1:0] pick_time();
    logic [63:0] span;
    logic [63:0] delta;
    span = {24'b0, window_setting} << 1;
    if (span == 0) span = 64'd4;
    delta = {$urandom, $urandom} % span;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return last_time + delta[TIME_W-1:0];
      5:             return last_time + TIME_W'(window_setting) - TIME_W'(1);
      6:             return last_time + TIME_W'(window_setting);
      7:             return last_time;
      8:             return last_time - TIME_W'($urandom_range(0, 1000));
      default:       return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [WINDOW_W-1:0] pick_window();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WINDOW_RESET;
      3:       return WINDOW_W'($urandom_range(1, 64));
      4:       return WINDOW_W'({$urandom, $urandom});
      default: return 40'd1000;
    endcase
  endfunction

  task automatic send_random_triggers(input int count);
    trigger_t trg;
    repeat (count) begin
      trg = make_trigger(pick_time(), pick_stat(), pick_stat(), TAG_W'($urandom),
                         $urandom_range(0, 15) == 0);
      send_trigger(trg);
    end
  endtask

  task automatic test_directed_cases();
    // Reset configuration: window 10 ms, snr and chisq both have to improve.
    send_trigger(make_trigger(61'd1000, 32'd10, 32'd100, 32'd1, 1'b0));
    send_trigger(make_trigger(61'd1005, 32'd20, 32'd50, 32'd2, 1'b0));
    send_trigger(make_trigger(61'd1015, 32'd30, 32'd60, 32'd3, 1'b0));
    send_trigger(make_trigger(61'd1015, 32'd20, 32'd50, 32'd4, 1'b0));
    send_trigger(make_trigger(61'd999, '1, '0, 32'd5, 1'b0));
    send_trigger(make_trigger(61'd10000998, '0, '1, 32'd6, 1'b0));
    send_trigger(make_trigger(61'd10000999, 32'd100, 32'd100, 32'd7, 1'b0));
    send_trigger(make_trigger(61'd10001000, 32'd50, 32'd50, 32'd8, 1'b1));
    send_trigger(make_trigger(61'd30000000, 32'd9, 32'd9, 32'd9, 1'b1));
    send_trigger(make_trigger(61'd40000000, 32'd10, 32'd10, 32'd10, 1'b0));
    send_trigger(make_trigger(61'd60000000, 32'd11, 32'd11, 32'd11, 1'b1));
    send_trigger(make_trigger('1, '1, '1, '1, 1'b0));
    send_trigger(make_trigger('0, '0, '0, '0, 1'b1));

    // Ratio mode with zero chi-square on either side.
    apply_settings(40'd1000, MODE_RATIO);
    send_trigger(make_trigger(61'd5000, 32'h0001_0000, 32'd0, 32'd14, 1'b0));
    send_trigger(make_trigger(61'd5001, 32'h0002_0000, 32'd0, 32'd15, 1'b0));
    send_trigger(make_trigger(61'd5002, '1, '1, 32'd16, 1'b0));
    send_trigger(make_trigger(61'd6100, 32'h0003_0000, 32'h0002_0000, 32'd17, 1'b0));
    send_trigger(make_trigger(61'd6101, 32'h0002_0000, 32'd0, 32'd18, 1'b0));
    send_trigger(make_trigger(61'd6102, 32'd0, 32'd0, 32'd19, 1'b1));

    // Undefined mode never replaces; a zero window only lets earlier times join.
    apply_settings('0, MODE_NONE);
    send_trigger(make_trigger(61'd100, 32'd5, 32'd5, 32'd20, 1'b0));
    send_trigger(make_trigger(61'd100, 32'd6, 32'd4, 32'd21, 1'b0));
    send_trigger(make_trigger(61'd99, '1, '0, 32'd22, 1'b0));
    send_trigger(make_trigger(61'd99, '1, '0, 32'd23, 1'b1));

    // SNR only, widest window.
    apply_settings('1, MODE_SNR);
    send_trigger(make_trigger(61'd0, 32'd7, 32'd0, 32'd24, 1'b0));
    send_trigger(make_trigger(61'h00FF_FFFF_FFFE, 32'd8, 32'd1, 32'd25, 1'b0));
    send_trigger(make_trigger(61'h01FF_FFFF_FFFD, 32'd1, 32'd1, 32'd26, 1'b1));
  endtask

  task automatic test_snr_chisq_mode();
    apply_settings(WINDOW_RESET, MODE_SNR_CHISQ);
    send_random_triggers(100);
    apply_settings(40'd1000, MODE_SNR_CHISQ);
    send_random_triggers(100);
    apply_settings('0, MODE_SNR_CHISQ);
    send_random_triggers(60);
    apply_settings('1, MODE_SNR_CHISQ);
    send_random_triggers(60);
  endtask

  task automatic test_ratio_mode();
    apply_settings(40'd1000, MODE_RATIO);
    send_random_triggers(150);
    apply_settings(WINDOW_RESET, MODE_RATIO);
    send_random_triggers(100);
    apply_settings(WINDOW_W'({$urandom, $urandom}), MODE_RATIO);
    send_random_triggers(70);
  endtask

  task automatic test_snr_mode();
    apply_settings(40'd1000, MODE_SNR);
    send_random_triggers(120);
    apply_settings(WINDOW_W'($urandom_range(1, 64)), MODE_SNR);
    send_random_triggers(100);
    apply_settings('1, MODE_SNR);
    send_random_triggers(100);
  endtask

  task automatic test_no_replace_mode();
    apply_settings(40'd1000, MODE_NONE);
    send_random_triggers(150);
    apply_settings('0, MODE_NONE);
    send_random_triggers(90);
  endtask

  task automatic test_window_extremes();
    logic [MODE_W-1:0] mode;
    for (int m = 0; m < 4; m++) begin
      mode = MODE_W'(m);
      apply_settings('0, mode);
      send_random_triggers(40);
      apply_settings('1, mode);
      send_random_triggers(40);
    end
  endtask

  // Short bursts, each followed by a full drain before the next setting.
  task automatic test_drain_pause();
    repeat (20) begin
      apply_settings(pick_window(), MODE_W'($urandom_range(0, 3)));
      send_random_triggers(18);
      wait_for_clusters();
    end
  endtask

  always @(posedge clk) begin : check_results
    trigger_t got;
    trigger_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.trig_time = out_end_time_ns;
      got.snr = out_snr;
      got.chisq = out_chisq;
      got.tag = out_tag;
      got.closing = out_run_last;
      if (pending_clusters.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected cluster: time %h snr %h chisq %h tag %h last %b",
                   got.trig_time, got.snr, got.chisq, got.tag, got.closing);
      end else begin
        want = pending_clusters.pop_front();
        if (got.trig_time !== want.trig_time || got.snr !== want.snr ||
            got.chisq !== want.chisq || got.tag !== want.tag ||
            got.closing !== want.closing) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("cluster mismatch: expected time %h snr %h chisq %h tag %h last %b",
                     want.trig_time, want.snr, want.chisq, want.tag, want.closing);
            $display("                  actual   time %h snr %h chisq %h tag %h last %b",
                     got.trig_time, got.snr, got.chisq, got.tag, got.closing);
          end
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // A cycle counts as idle when neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 29;
    receiver_idle_pct = 81;
    test_directed_cases();
    test_snr_chisq_mode();
    test_ratio_mode();

    sender_idle_pct = 81;
    receiver_idle_pct = 29;
    test_snr_mode();
    test_no_replace_mode();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_window_extremes();
    test_drain_pause();

    wait_for_clusters();
    if (mismatches == 0 && pending_clusters.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
